@@ rtl/core/ctb_pkg.sv @@
// package for the countdown timer bank: command codes, result kinds, shared types
package ctb_pkg;
  localparam int TIMERS_DEF = 32;
  localparam int IDX_W = 5;
  localparam int MAX_REPORTS = 32;

  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_SET   = 3'd1;
  localparam logic [2:0] MODE_GET   = 3'd2;
  localparam logic [2:0] MODE_HOLD  = 3'd3;
  localparam logic [2:0] MODE_STOP  = 3'd4;
  localparam logic [2:0] MODE_STOPALL = 3'd5;
  localparam logic [2:0] MODE_TICK  = 3'd6;
  localparam logic [2:0] MODE_SERV  = 3'd7;

  localparam logic [1:0] KIND_GET  = 2'd0;
  localparam logic [1:0] KIND_EXP  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  localparam logic [31:0] F_TENTH  = 32'd40;
  localparam logic [31:0] F_SECOND = 32'd400;
  localparam logic [31:0] F_MINUTE = 32'd24000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  idx;
    logic        in_range;
    logic [31:0] scaled;
    logic [31:0] duration;
    logic [1:0]  unit;
    logic        notify;
    logic        hold;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  which;
    logic [31:0] value;
    logic        last;
  } res_t;

  function automatic logic [31:0] factor(input logic [1:0] u);
    logic [31:0] f;
    case (u)
      2'd0: f = 32'd1;
      2'd1: f = F_TENTH;
      2'd2: f = F_SECOND;
      default: f = F_MINUTE;
    endcase
    return f;
  endfunction
endpackage

@@ rtl/core/ctb_front.sv @@
// front end: accepts requests, checks the index, scales start durations, queues commands
module ctb_front #(
  parameter int TIMERS = ctb_pkg::TIMERS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      mode,
  input  logic [4:0]      idx,
  input  logic [31:0]     duration,
  input  logic [1:0]      unit,
  input  logic            notify,
  input  logic            hold,
  output logic            q_valid,
  input  logic            q_ready,
  output ctb_pkg::cmd_t   q_cmd
);
  // stage 1: register request; stage 2: 2-entry queue with scaled value
  logic          s1_v_r, s1_v_nxt;
  ctb_pkg::cmd_t s1_r;
  ctb_pkg::cmd_t q_r [2];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          wp_r, rp_r;
  logic          push, pop;
  ctb_pkg::cmd_t s1_done;

  assign pop  = q_valid && q_ready;
  assign push = s1_v_r && (cnt_r != 2'd2);
  assign in_ready = !s1_v_r || push;
  assign s1_v_nxt = (in_valid && in_ready) || (s1_v_r && !push);
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_comb begin
    s1_done = s1_r;
    s1_done.scaled = s1_r.duration * ctb_pkg::factor(s1_r.unit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r.mode <= mode;
      s1_r.idx <= idx;
      s1_r.in_range <= ({27'd0, idx} < 32'(TIMERS));
      s1_r.scaled <= 32'd0;
      s1_r.duration <= duration;
      s1_r.unit <= unit;
      s1_r.notify <= notify;
      s1_r.hold <= hold;
    end
    if (push) q_r[wp_r] <= s1_done;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[rp_r];
endmodule

@@ rtl/core/ctb_div.sv @@
// divider by unit factor: shifts out the power of two, then multiplies by a reciprocal
module ctb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [1:0]  unit,
  output logic        done,
  output logic [31:0] quot
);
  // 40 = 8 * 5, 400 = 16 * 25, 24000 = 64 * 375
  localparam logic [29:0] M_TENTH  = 30'd858993460;
  localparam logic [29:0] M_SECOND = 30'd343597384;
  localparam logic [29:0] M_MINUTE = 30'd91625969;

  logic        v_r, done_r;
  logic [1:0]  u_r;
  logic [31:0] n_r, n_nxt;
  logic [29:0] m_r, m_nxt;
  logic [31:0] q_r, q_nxt;
  logic [58:0] prod;

  always_comb begin
    case (unit)
      2'd0: begin
        n_nxt = dividend;
        m_nxt = '0;
      end
      2'd1: begin
        n_nxt = {3'd0, dividend[31:3]};
        m_nxt = M_TENTH;
      end
      2'd2: begin
        n_nxt = {4'd0, dividend[31:4]};
        m_nxt = M_SECOND;
      end
      default: begin
        n_nxt = {6'd0, dividend[31:6]};
        m_nxt = M_MINUTE;
      end
    endcase
    prod = 59'(n_r[28:0]) * 59'(m_r);
    case (u_r)
      2'd0: q_nxt = n_r;
      2'd1: q_nxt = 32'(prod >> 32);
      2'd2: q_nxt = 32'(prod >> 33);
      default: q_nxt = 32'(prod >> 35);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v_r <= start;
      if (start) done_r <= 1'b0;
      else if (v_r) done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      u_r <= unit;
      n_r <= n_nxt;
      m_r <= m_nxt;
    end
    if (v_r) q_r <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

@@ rtl/core/ctb_back.sv @@
// back end: timer state, per-entry walks for tick, stop-all and service, result register
module ctb_back #(
  parameter int TIMERS = ctb_pkg::TIMERS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  ctb_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output ctb_pkg::res_t out_res
);
  localparam int TW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_SEL  = 3'd4;
  localparam logic [2:0] S_OUT_FLUSH = 3'd5;

  logic [31:0] rem_r   [TIMERS];
  logic [1:0]  unit_r  [TIMERS];
  logic [TIMERS-1:0] exp_r, pau_r, nfy_r;

  logic [2:0]  st_r;
  ctb_pkg::cmd_t c_r;
  logic [TW-1:0] w_r;
  logic        found_r;
  logic [5:0]  nrep_r;
  logic        ov_r;
  ctb_pkg::res_t res_r;
  logic        pend_r;
  ctb_pkg::res_t pend_res_r;
  ctb_pkg::res_t res_r_hold_r;
  logic [TW-1:0] ci;
  logic        wlast;
  logic        rep;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic        slot_free;

  assign ci = TW'(c_r.idx);
  assign wlast = ({{(32-TW){1'b0}}, w_r} == 32'(TIMERS - 1));
  assign rep = exp_r[w_r] && nfy_r[w_r] && (nrep_r != 6'(ctb_pkg::MAX_REPORTS));
  assign slot_free = !ov_r || out_ready;
  assign q_ready = (st_r == S_IDLE);
  assign div_start = (st_r == S_SEL);

  ctb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(rem_r[ci]), .unit(unit_r[ci]),
    .done(div_done), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      pend_r <= 1'b0;
      w_r <= '0;
      found_r <= 1'b0;
      nrep_r <= '0;
      exp_r <= '0;
      pau_r <= '0;
      nfy_r <= '0;
      for (int i = 0; i < TIMERS; i++) begin
        rem_r[i] <= 32'd0;
        unit_r[i] <= 2'd0;
      end
    end else begin
      ov_r <= (pend_r && slot_free) || (ov_r && !out_ready);
      if (pend_r && slot_free) begin
        res_r <= pend_res_r;
        pend_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            c_r <= q_cmd;
            w_r <= '0;
            found_r <= 1'b0;
            nrep_r <= '0;
            if (q_cmd.mode inside {ctb_pkg::MODE_TICK, ctb_pkg::MODE_STOPALL,
                                   ctb_pkg::MODE_SERV}) begin
              st_r <= S_WALK;
            end else if (q_cmd.in_range) begin
              st_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          st_r <= S_IDLE;
          case (c_r.mode)
            ctb_pkg::MODE_START: begin
              unit_r[ci] <= c_r.unit;
              rem_r[ci] <= c_r.scaled;
              exp_r[ci] <= (c_r.scaled == 32'd0);
              nfy_r[ci] <= c_r.notify;
            end
            ctb_pkg::MODE_SET: rem_r[ci] <= c_r.duration * ctb_pkg::factor(unit_r[ci]);
            ctb_pkg::MODE_GET: st_r <= S_SEL;
            ctb_pkg::MODE_HOLD: pau_r[ci] <= c_r.hold;
            ctb_pkg::MODE_STOP: begin
              rem_r[ci] <= 32'd0;
              unit_r[ci] <= 2'd0;
              exp_r[ci] <= 1'b0;
              pau_r[ci] <= 1'b0;
              nfy_r[ci] <= 1'b0;
            end
            default: ;
          endcase
        end
        S_SEL: st_r <= S_DIV;
        S_DIV: begin
          if (div_done && !pend_r) begin
            pend_r <= 1'b1;
            pend_res_r <= '{kind: ctb_pkg::KIND_GET, which: c_r.idx, value: div_q,
                            last: 1'b1};
            st_r <= S_IDLE;
          end
        end
        S_WALK: begin
          if (!pend_r) begin
            w_r <= w_r + TW'(1);
            if (wlast) st_r <= (c_r.mode == ctb_pkg::MODE_SERV) ? S_OUT_FLUSH : S_IDLE;
            case (c_r.mode)
              ctb_pkg::MODE_STOPALL: begin
                rem_r[w_r] <= 32'd0;
                unit_r[w_r] <= 2'd0;
                exp_r[w_r] <= 1'b0;
                pau_r[w_r] <= 1'b0;
                nfy_r[w_r] <= 1'b0;
              end
              ctb_pkg::MODE_TICK: begin
                if (rem_r[w_r] != 32'd0 && !pau_r[w_r]) begin
                  rem_r[w_r] <= rem_r[w_r] - 32'd1;
                  if (rem_r[w_r] == 32'd1) exp_r[w_r] <= 1'b1;
                end
              end
              default: begin
                exp_r[w_r] <= 1'b0;
                if (rep) begin
                  found_r <= 1'b1;
                  nrep_r <= nrep_r + 6'd1;
                  if (found_r) begin
                    pend_r <= 1'b1;
                    pend_res_r <= res_r_hold_r;
                  end
                  res_r_hold_r <= '{kind: ctb_pkg::KIND_EXP, which: 5'(w_r),
                                    value: 32'd0, last: 1'b0};
                end
              end
            endcase
          end
        end
        S_OUT_FLUSH: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
            if (found_r) begin
              pend_res_r <= '{kind: ctb_pkg::KIND_EXP, which: res_r_hold_r.which,
                              value: 32'd0, last: 1'b1};
            end else begin
              pend_res_r <= '{kind: ctb_pkg::KIND_NONE, which: 5'd0,
                              value: 32'd0, last: 1'b1};
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_res = res_r;
endmodule

@@ rtl/core/countdown_timer_bank.sv @@
// top level of the countdown timer bank
// Requests pass a registered front end and a two-entry queue, so a new request is
// taken while the back end still works. In the back end start, set, hold and stop
// pass the output state, and a request with an out-of-range index is dropped in
// the idle state; get divides by the unit with a reciprocal multiply; tick and
// stop-all walk the timers one entry per cycle while no result is pending;
// service walks them the same way and then sends its final result.
// Results pass a one-deep pending register and the output register, and a stalled
// output holds the back end while a result waits.
module countdown_timer_bank #(
  parameter int TIMERS = ctb_pkg::TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // mode, timer_index, duration, unit, notify, hold
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [39:0] out_tdata, // kind, which_timer, value
  output logic        out_tlast
);
  logic          q_valid, q_ready;
  ctb_pkg::cmd_t q_cmd;
  ctb_pkg::res_t res;

  ctb_front #(.TIMERS(TIMERS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .mode(in_tdata[2:0]), .idx(in_tdata[7:3]), .duration(in_tdata[39:8]),
    .unit(in_tdata[41:40]), .notify(in_tdata[42]), .hold(in_tdata[43]),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  ctb_back #(.TIMERS(TIMERS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {1'b0, res.value, res.which, res.kind};
  assign out_tlast = res.last;
endmodule

@@ rtl/core/ctb_checker.sv @@
// port checker for the countdown timer bank, bound to the top level
module ctb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_inhold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid)
    else $error("request withdrawn before accept");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("bad result kind");
  a_lastk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == 2'd0 || out_tdata[1:0] == 2'd2) |-> out_tlast)
    else $error("single result without last");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
endmodule

bind countdown_timer_bank ctb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

@@ verif/countdown_timer_bank_test.sv @@
// testbench for the countdown timer bank: command requests against a behavioral timer model
module countdown_timer_bank_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = 32;
  localparam int CYCLE_LIMIT = 900000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  logic        out_tvalid;
  logic [39:0] out_tdata;
  logic        out_tlast;

  countdown_timer_bank u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timer state mirror
  logic [31:0] ticks_left [NT];
  logic        expired    [NT];
  logic        paused     [NT];
  logic [1:0]  unit_of    [NT];
  logic        notify_on  [NT];

  ctb_pkg::res_t pending_results [$];
  int   errors = 0;
  int   cycles = 0;
  int   hold_off = 0;
  int   gap_left = 0;
  bit   quiet = 1'b0;

  function automatic logic [31:0] unit_scale(input logic [1:0] u);
    case (u)
      2'd0: return 32'd1;
      2'd1: return 32'd40;
      2'd2: return 32'd400;
      default: return 32'd24000;
    endcase
  endfunction

  function automatic void clear_timer(input int t);
    ticks_left[t] = '0;
    expired[t] = 1'b0;
    paused[t] = 1'b0;
    unit_of[t] = '0;
    notify_on[t] = 1'b0;
  endfunction

  function automatic void apply_request(input logic [2:0] mode, input logic [4:0] idx,
                                        input logic [31:0] dur, input logic [1:0] u,
                                        input logic nfy, input logic hld);
    logic [31:0] scaled;
    ctb_pkg::res_t r;
    int n;
    n = 0;
    case (mode)
      ctb_pkg::MODE_START: begin
        scaled = dur * unit_scale(u);
        unit_of[idx] = u;
        ticks_left[idx] = scaled;
        expired[idx] = (scaled == 0);
        notify_on[idx] = nfy;
      end
      ctb_pkg::MODE_SET: ticks_left[idx] = dur * unit_scale(unit_of[idx]);
      ctb_pkg::MODE_GET: begin
        r.kind = ctb_pkg::KIND_GET;
        r.which = idx;
        r.value = ticks_left[idx] / unit_scale(unit_of[idx]);
        r.last = 1'b1;
        pending_results.push_back(r);
      end
      ctb_pkg::MODE_HOLD: paused[idx] = hld;
      ctb_pkg::MODE_STOP: clear_timer(idx);
      ctb_pkg::MODE_STOPALL: for (int t = 0; t < NT; t++) clear_timer(t);
      ctb_pkg::MODE_TICK: begin
        for (int t = 0; t < NT; t++) begin
          if (ticks_left[t] != 0 && !paused[t]) begin
            ticks_left[t]--;
            if (ticks_left[t] == 0) expired[t] = 1'b1;
          end
        end
      end
      default: begin
        for (int t = 0; t < NT; t++) begin
          if (expired[t]) begin
            if (notify_on[t] && n < ctb_pkg::MAX_REPORTS) begin
              r.kind = ctb_pkg::KIND_EXP;
              r.which = t[4:0];
              r.value = '0;
              r.last = 1'b0;
              pending_results.push_back(r);
              n++;
            end
            expired[t] = 1'b0;
          end
        end
        if (n == 0) begin
          r.kind = ctb_pkg::KIND_NONE;
          r.which = '0;
          r.value = '0;
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          pending_results[$].last = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic send_request(input logic [2:0] mode, input logic [4:0] idx,
                              input logic [31:0] dur, input logic [1:0] u,
                              input logic nfy, input logic hld);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, hld, nfy, u, dur, idx, mode};
    do @(posedge clk); while (!in_tready);
    apply_request(mode, idx, dur, u, nfy, hld);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_request(input bit short_times);
    logic [2:0] m;
    logic [31:0] d;
    int p;
    p = $urandom_range(0, 99);
    if (p < 22) m = ctb_pkg::MODE_TICK;
    else if (p < 40) m = ctb_pkg::MODE_START;
    else if (p < 52) m = ctb_pkg::MODE_GET;
    else if (p < 62) m = ctb_pkg::MODE_SERV;
    else if (p < 72) m = ctb_pkg::MODE_SET;
    else if (p < 82) m = ctb_pkg::MODE_HOLD;
    else if (p < 92) m = ctb_pkg::MODE_STOP;
    else if (p < 95) m = ctb_pkg::MODE_STOPALL;
    else m = 3'($urandom_range(0, 7));
    d = short_times ? $urandom_range(0, 6) : $urandom;
    send_request(m, 5'($urandom_range(0, 31)), d,
                 short_times ? 2'd0 : 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_directed();
    send_request(ctb_pkg::MODE_SERV, 5'd0, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_GET, 5'd31, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_START, 5'd0, 32'hFFFFFFFF, 2'd3, 1'b1, 1'b0);
    send_request(ctb_pkg::MODE_GET, 5'd0, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_START, 5'd31, 32'hFFFFFFFF, 2'd0, 1'b1, 1'b1);
    send_request(ctb_pkg::MODE_START, 5'd1, '0, 2'd2, 1'b1, 1'b0);
    send_request(ctb_pkg::MODE_START, 5'd2, '0, 2'd1, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_START, 5'd3, 32'd1, 2'd1, 1'b1, 1'b0);
    send_request(ctb_pkg::MODE_SET, 5'd3, 32'd0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_START, 5'd4, 32'd2, 2'd0, 1'b1, 1'b0);
    send_request(ctb_pkg::MODE_HOLD, 5'd4, '0, 2'd0, 1'b0, 1'b1);
    send_request(ctb_pkg::MODE_TICK, 5'd0, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_GET, 5'd4, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_HOLD, 5'd4, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_TICK, 5'd0, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_TICK, 5'd0, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_SERV, 5'd0, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_STOP, 5'd0, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_GET, 5'd0, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_STOPALL, 5'd0, '0, 2'd0, 1'b0, 1'b0);
    send_request(ctb_pkg::MODE_GET, 5'd31, '0, 2'd0, 1'b0, 1'b0);
    drain();
  endtask

  // every timer expires with notify so one service reports all 32
  task automatic test_full_report();
    for (int t = 0; t < NT; t++)
      send_request(ctb_pkg::MODE_START, t[4:0], '0, 2'($urandom_range(0, 3)), 1'b1, 1'b0);
    send_request(ctb_pkg::MODE_SERV, 5'd0, '0, 2'd0, 1'b0, 1'b0);
    drain();
  endtask

  // gets pile up behind a stalled receiver until the input stalls
  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 10; i++)
      send_request(ctb_pkg::MODE_GET, 5'($urandom_range(0, 31)), '0, 2'd0, 1'b0, 1'b0);
    for (int i = 0; i < 10; i++) random_request(1'b1);
    drain();
  endtask

  task automatic test_random();
    for (int i = 0; i < 380; i++) begin
      if (i >= 300) quiet = 1'b1;
      random_request(i % 3 != 0);
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      gap_left <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ctb_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %h last %b", out_tdata, out_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.kind) begin
          $error("kind expected %0d actual %0d", want.kind, out_tdata[1:0]);
          errors++;
        end
        if (out_tdata[6:2] !== want.which) begin
          $error("which_timer expected %0d actual %0d", want.which, out_tdata[6:2]);
          errors++;
        end
        if (out_tdata[38:7] !== want.value) begin
          $error("value expected %0d actual %0d", want.value, out_tdata[38:7]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last expected %0b actual %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int t = 0; t < NT; t++) clear_timer(t);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_report();
    test_backpressure();
    test_random();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/ctb_pkg.sv
rtl/core/ctb_front.sv
rtl/core/ctb_div.sv
rtl/core/ctb_back.sv
rtl/core/countdown_timer_bank.sv
rtl/core/ctb_checker.sv
verif/countdown_timer_bank_test.sv
